// ----- rtl/bcd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_pkg
// Shared types, codes and helpers for the button click detector.
// ----------------------------------------------------------------------------
package bcd_pkg;

    localparam int TIME_BITS = 32;

    typedef logic [TIME_BITS-1:0] tstamp_t;

    localparam logic [1:0] CFG_DEBOUNCE_TIME   = 2'd0;
    localparam logic [1:0] CFG_CLICK_GAP       = 2'd1;
    localparam logic [1:0] CFG_LONG_PRESS_TIME = 2'd2;
    localparam logic [1:0] CFG_ACTIVE_LOW      = 2'd3;

    localparam logic [15:0] DEBOUNCE_TIME_RST   = 16'd50;
    localparam logic [15:0] CLICK_GAP_RST       = 16'd400;
    localparam logic [15:0] LONG_PRESS_TIME_RST = 16'd800;
    localparam logic        ACTIVE_LOW_RST      = 1'b1;

    localparam logic [1:0] EV_NONE       = 2'd0;
    localparam logic [1:0] EV_SINGLE     = 2'd1;
    localparam logic [1:0] EV_DOUBLE     = 2'd2;
    localparam logic [1:0] EV_LONG_START = 2'd3;

    typedef struct packed {
        logic [15:0] debounce_time;
        logic [15:0] click_gap;
        logic [15:0] long_press_time;
        logic        active_low;
    } cfg_t;

    // millisecond input stamp to the internal wrap width
    function automatic tstamp_t to_tstamp(input logic [31:0] ms);
        logic [63:0] wide;
        wide = {32'd0, ms};
        return wide[TIME_BITS-1:0];
    endfunction

    // 16-bit interval register to the internal wrap width
    function automatic tstamp_t cfg_to_tstamp(input logic [15:0] val);
        logic [63:0] wide;
        wide = {48'd0, val};
        return wide[TIME_BITS-1:0];
    endfunction

endpackage

// ----- rtl/bcd_debounce.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_debounce
// Polarity fix-up and time-based debounce of the sampled button level.
// ----------------------------------------------------------------------------
module bcd_debounce (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              raw_level,
    input  bcd_pkg::tstamp_t  now,
    input  bcd_pkg::cfg_t     cfg,
    output logic              stable_next
);

    logic             last_sample_reg, last_sample_next;
    logic             sample_seen_reg, sample_seen_next;
    bcd_pkg::tstamp_t change_time_reg, change_time_next;
    logic             stable_reg;
    logic             sample;
    bcd_pkg::tstamp_t elapsed;

    assign sample  = raw_level ^ cfg.active_low;
    assign elapsed = now - change_time_reg;

    always_comb begin
        last_sample_next = last_sample_reg;
        sample_seen_next = sample_seen_reg;
        change_time_next = change_time_reg;
        stable_next      = stable_reg;
        if (!sample_seen_reg || (sample != last_sample_reg)) begin
            last_sample_next = sample;
            sample_seen_next = 1'b1;
            change_time_next = now;
        end else if (elapsed >= bcd_pkg::cfg_to_tstamp(cfg.debounce_time)) begin
            stable_next = sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_sample_reg <= 1'b0;
            sample_seen_reg <= 1'b0;
            change_time_reg <= '0;
            stable_reg      <= 1'b0;
        end else if (en) begin
            last_sample_reg <= last_sample_next;
            sample_seen_reg <= sample_seen_next;
            change_time_reg <= change_time_next;
            stable_reg      <= stable_next;
        end
    end

endmodule

// ----- rtl/bcd_click_fsm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_click_fsm
// Click, double-click and long-press state machine on the debounced level.
// ----------------------------------------------------------------------------
module bcd_click_fsm (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              act,
    input  bcd_pkg::tstamp_t  now,
    input  bcd_pkg::cfg_t     cfg,
    output logic [1:0]        event_next
);

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_DOWN     = 3'd1,
        ST_UP       = 3'd2,
        ST_COUNT    = 3'd3,
        ST_HELD     = 3'd4,
        ST_HELD_END = 3'd5
    } state_t;

    state_t           state_reg, state_next;
    logic [1:0]       count_reg, count_next;
    bcd_pkg::tstamp_t start_reg, start_next;
    bcd_pkg::tstamp_t wait_ms;

    assign wait_ms = now - start_reg;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        start_next = start_reg;
        event_next = bcd_pkg::EV_NONE;
        case (state_reg)
            ST_IDLE: begin
                if (act) begin
                    state_next = ST_DOWN;
                    start_next = now;
                    count_next = 2'd0;
                end
            end
            ST_DOWN: begin
                if (!act) begin
                    state_next = ST_UP;
                    start_next = now;
                end else if (wait_ms > bcd_pkg::cfg_to_tstamp(cfg.long_press_time)) begin
                    event_next = bcd_pkg::EV_LONG_START;
                    state_next = ST_HELD;
                end
            end
            ST_UP: begin
                if (count_reg != 2'd3) begin
                    count_next = count_reg + 2'd1;
                end
                state_next = ST_COUNT;
            end
            ST_COUNT: begin
                if (act) begin
                    state_next = ST_DOWN;
                    start_next = now;
                end else if ((wait_ms >= bcd_pkg::cfg_to_tstamp(cfg.click_gap))
                             || (count_reg == 2'd2)) begin
                    if (count_reg == 2'd1) begin
                        event_next = bcd_pkg::EV_SINGLE;
                    end else if (count_reg == 2'd2) begin
                        event_next = bcd_pkg::EV_DOUBLE;
                    end
                    state_next = ST_IDLE;
                    count_next = 2'd0;
                    start_next = '0;
                end
            end
            ST_HELD: begin
                if (!act) begin
                    state_next = ST_HELD_END;
                    start_next = now;
                end
            end
            ST_HELD_END: begin
                state_next = ST_IDLE;
                count_next = 2'd0;
                start_next = '0;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= 2'd0;
            start_reg <= '0;
        end else if (en) begin
            state_reg <= state_next;
            count_reg <= count_next;
            start_reg <= start_next;
        end
    end

endmodule

// ----- rtl/button_click_detector_core.sv -----
`timescale 1ns / 1ps
// A sample is held in the input register, then its result is registered on m_tdata.
// Throughput: one sample per cycle unless the sink stalls; the input register refills
// as the result is taken. Each result depends on state left by the previous sample.
// Reset (aresetn low, synchronous): pipeline empties, settings return to defaults,
// debounce and click state return to idle with an inactive level.
// ----------------------------------------------------------------------------
// button_click_detector_core
// Debounced button sampler reporting single, double click and long press.
// ----------------------------------------------------------------------------
module button_click_detector_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // [0] raw_level, [32:1] now_ms, [39:33] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [1:0] event_res, [2] pressed, [7:3] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    bcd_pkg::cfg_t    cfg_reg;
    logic             in_valid_reg;
    logic             in_raw_reg;
    logic [31:0]      in_now_reg;
    logic             m_valid_reg;
    logic [7:0]       m_data_reg;
    logic             advance;
    logic             pressed_next;
    logic [1:0]       event_next;
    bcd_pkg::tstamp_t now;

    assign advance   = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign now       = bcd_pkg::to_tstamp(in_now_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg            <= 1'b0;
            m_valid_reg             <= 1'b0;
            cfg_reg.debounce_time   <= bcd_pkg::DEBOUNCE_TIME_RST;
            cfg_reg.click_gap       <= bcd_pkg::CLICK_GAP_RST;
            cfg_reg.long_press_time <= bcd_pkg::LONG_PRESS_TIME_RST;
            cfg_reg.active_low      <= bcd_pkg::ACTIVE_LOW_RST;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    bcd_pkg::CFG_DEBOUNCE_TIME:   cfg_reg.debounce_time   <= cfg_data;
                    bcd_pkg::CFG_CLICK_GAP:       cfg_reg.click_gap       <= cfg_data;
                    bcd_pkg::CFG_LONG_PRESS_TIME: cfg_reg.long_press_time <= cfg_data;
                    bcd_pkg::CFG_ACTIVE_LOW:      cfg_reg.active_low      <= cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_raw_reg <= s_tdata[0];
            in_now_reg <= s_tdata[32:1];
        end
        if (advance) begin
            m_data_reg <= {5'd0, pressed_next, event_next};
        end
    end

    bcd_debounce u_debounce (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (advance),
        .raw_level   (in_raw_reg),
        .now         (now),
        .cfg         (cfg_reg),
        .stable_next (pressed_next)
    );

    bcd_click_fsm u_click_fsm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (advance),
        .act        (pressed_next),
        .now        (now),
        .cfg        (cfg_reg),
        .event_next (event_next)
    );

endmodule

// ----- rtl/bcd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_checker
// Port-level checks for the button click detector core.
// ----------------------------------------------------------------------------
module bcd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);

    // result held while stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    // long press start is only seen while pressed
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[1:0] == bcd_pkg::EV_LONG_START)) |-> m_tdata[2])
        else $error("long press start without pressed level");

    // clicks are only reported after release
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && ((m_tdata[1:0] == bcd_pkg::EV_SINGLE)
                      || (m_tdata[1:0] == bcd_pkg::EV_DOUBLE))) |-> !m_tdata[2])
        else $error("click reported while pressed");

    // no result right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind button_click_detector_core bcd_checker u_bcd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives button samples through button_click_detector_core under random
// source gaps and sink stalls. A scoreboard tracks debounce and click state
// itself and checks every output transaction in order. Register settings are
// changed between runs while the core is idle.
// ----------------------------------------------------------------------------
class click_event_checker;

    typedef enum logic [2:0] {
        PH_IDLE, PH_DOWN, PH_UP, PH_COUNT, PH_HELD, PH_HELD_END
    } click_phase_t;

    typedef struct packed {
        logic [1:0] event_res;
        logic       pressed;
    } click_result_t;

    logic [15:0]      debounce_ms;
    logic [15:0]      gap_ms;
    logic [15:0]      long_ms;
    logic             act_low;

    logic             last_lvl;
    logic             seen;
    bcd_pkg::tstamp_t change_t;
    logic             stable;
    click_phase_t     phase;
    logic [1:0]       clicks;
    bcd_pkg::tstamp_t phase_t;

    click_result_t expected_events[$];
    int            errors;

    function new();
        debounce_ms = bcd_pkg::DEBOUNCE_TIME_RST;
        gap_ms      = bcd_pkg::CLICK_GAP_RST;
        long_ms     = bcd_pkg::LONG_PRESS_TIME_RST;
        act_low     = bcd_pkg::ACTIVE_LOW_RST;
        last_lvl    = 1'b0;
        seen        = 1'b0;
        change_t    = '0;
        stable      = 1'b0;
        errors      = 0;
        clear_clicks();
    endfunction

    function void clear_clicks();
        phase   = PH_IDLE;
        clicks  = 2'd0;
        phase_t = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
        case (idx)
            bcd_pkg::CFG_DEBOUNCE_TIME:   debounce_ms = val;
            bcd_pkg::CFG_CLICK_GAP:       gap_ms = val;
            bcd_pkg::CFG_LONG_PRESS_TIME: long_ms = val;
            bcd_pkg::CFG_ACTIVE_LOW:      act_low = val[0];
            default: ;
        endcase
    endfunction

    function void note_sample(logic raw, logic [31:0] now_ms);
        logic             lvl;
        logic             act;
        bcd_pkg::tstamp_t now;
        bcd_pkg::tstamp_t since_phase;
        logic [1:0]       ev;
        click_result_t    res;
        lvl = raw ^ act_low;
        now = bcd_pkg::tstamp_t'(now_ms);
        ev  = bcd_pkg::EV_NONE;
        if (!seen || lvl != last_lvl) begin
            change_t = now;
            last_lvl = lvl;
            seen     = 1'b1;
        end else if (bcd_pkg::tstamp_t'(now - change_t)
                     >= bcd_pkg::tstamp_t'(debounce_ms)) begin
            stable = lvl;
        end
        act         = stable;
        since_phase = now - phase_t;
        case (phase)
            PH_IDLE: begin
                if (act) begin
                    phase   = PH_DOWN;
                    phase_t = now;
                    clicks  = 2'd0;
                end
            end
            PH_DOWN: begin
                if (!act) begin
                    phase   = PH_UP;
                    phase_t = now;
                end else if (since_phase > bcd_pkg::tstamp_t'(long_ms)) begin
                    ev    = bcd_pkg::EV_LONG_START;
                    phase = PH_HELD;
                end
            end
            PH_UP: begin
                if (clicks != 2'd3) begin
                    clicks = clicks + 2'd1;
                end
                phase = PH_COUNT;
            end
            PH_COUNT: begin
                if (act) begin
                    phase   = PH_DOWN;
                    phase_t = now;
                end else if (since_phase >= bcd_pkg::tstamp_t'(gap_ms) || clicks == 2'd2) begin
                    if (clicks == 2'd1) begin
                        ev = bcd_pkg::EV_SINGLE;
                    end else if (clicks == 2'd2) begin
                        ev = bcd_pkg::EV_DOUBLE;
                    end
                    clear_clicks();
                end
            end
            PH_HELD: begin
                if (!act) begin
                    phase   = PH_HELD_END;
                    phase_t = now;
                end
            end
            PH_HELD_END: clear_clicks();
            default: phase = PH_IDLE;
        endcase
        res.event_res = ev;
        res.pressed   = stable;
        expected_events.push_back(res);
    endfunction

    function void check_event(logic [1:0] ev, logic pressed);
        click_result_t exp;
        if (expected_events.size() == 0) begin
            $error("unexpected transaction: event_res=%0d pressed=%0d", ev, pressed);
            errors++;
            return;
        end
        exp = expected_events.pop_front();
        if (ev !== exp.event_res) begin
            $error("event_res mismatch: expected %0d, actual %0d", exp.event_res, ev);
            errors++;
        end
        if (pressed !== exp.pressed) begin
            $error("pressed mismatch: expected %0d, actual %0d", exp.pressed, pressed);
            errors++;
        end
    endfunction

endclass

module testbench;

    localparam int STALL_LIMIT   = 2000;
    localparam int NUM_SETTINGS  = 8;
    localparam int ITEMS_PER_RUN = 145;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;    // [0] raw_level, [32:1] now_ms, [39:33] zero
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;           // [1:0] event_res, [2] pressed, [7:3] zero
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    click_event_checker sb = new();

    int unsigned burst_left = 0;
    int unsigned rx_count   = 0;
    int unsigned rx_mode    = 0;
    logic [7:0]  rx_pattern = '1;

    button_click_detector_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // sink stall pattern, re-chosen whenever rx_count wraps to zero
    always @(negedge aclk) begin
        if (rx_count == 0) begin
            rx_mode    = $urandom_range(0, 3);
            rx_pattern = 8'($urandom());
        end
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= rx_pattern[rx_count % 8];
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
        rx_count = (rx_count + 1) % 64;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_event(m_tdata[1:0], m_tdata[2]);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                    || (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("button_click_detector_core test failed");
        $finish;
    end

    task automatic send_sample(input logic raw, input logic [31:0] now_ms);
        int unsigned gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(1, 5);
        end
        burst_left--;
        @(negedge aclk);
        while (gap > 0) begin
            s_tvalid <= 1'b0;
            gap--;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, now_ms, raw};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_sample(raw, now_ms);
    endtask

    // hold off the source until every pending result has been taken
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.expected_events.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // default registers: active low, debounce 50, gap 400, long press 800
    task automatic run_directed();
        send_sample(1'b1, 32'd0);
        send_sample(1'b1, 32'd60);
        send_sample(1'b0, 32'd100);
        send_sample(1'b0, 32'd160);
        send_sample(1'b1, 32'd200);
        send_sample(1'b1, 32'd260);
        send_sample(1'b1, 32'd270);
        send_sample(1'b1, 32'd700);     // single click
        send_sample(1'b0, 32'd800);
        send_sample(1'b0, 32'd860);
        send_sample(1'b1, 32'd900);
        send_sample(1'b1, 32'd960);
        send_sample(1'b1, 32'd970);
        send_sample(1'b0, 32'd1000);    // pressed again while counting
        send_sample(1'b0, 32'd1060);
        send_sample(1'b1, 32'd1100);
        send_sample(1'b1, 32'd1160);
        send_sample(1'b1, 32'd1170);
        send_sample(1'b1, 32'd1180);    // double click
        send_sample(1'b0, 32'hFFFF_FFFF);
        send_sample(1'b0, 32'h0000_0040);  // time wraps
        send_sample(1'b0, 32'h0000_0380);  // long press start
        send_sample(1'b1, 32'h0000_0400);
        send_sample(1'b1, 32'h0000_0450);
        send_sample(1'b1, 32'h0000_0460);
    endtask

    task automatic run_random(input int n, input int unsigned deb, input int unsigned gap,
                              input int unsigned lng, input logic act_low);
        logic [31:0] t;
        logic        lvl;
        int unsigned step_max;
        int unsigned step;
        int unsigned hold;
        int unsigned held_for;
        int          roll;
        t        = $urandom();
        lvl      = 1'b0;
        hold     = 0;
        held_for = 0;
        step_max = (deb + gap + lng) / 24 + 1;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 5) begin
                send_sample(1'($urandom_range(0, 1)), $urandom());
            end else begin
                step     = $urandom_range(0, step_max);
                t        = t + step;
                held_for = held_for + step;
                if (held_for >= hold) begin
                    lvl      = ~lvl;
                    held_for = 0;
                    roll     = $urandom_range(0, 99);
                    if (roll < 15) begin
                        hold = $urandom_range(0, deb);
                    end else if (lvl) begin
                        hold = (roll < 70) ? deb + $urandom_range(0, lng)
                                           : deb + lng + $urandom_range(1, lng / 2 + 8);
                    end else begin
                        hold = (roll < 60) ? deb + $urandom_range(0, gap)
                                           : deb + gap + $urandom_range(0, gap / 2 + 8);
                    end
                end
                send_sample(lvl ^ act_low, t);
            end
        end
    endtask

    initial begin
        logic [15:0] deb;
        logic [15:0] gap;
        logic [15:0] lng;
        logic        act_low;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        run_directed();
        for (int p = 0; p < NUM_SETTINGS; p++) begin
            drain();
            case (p)
                0: begin deb = 16'd0;     gap = 16'd0;     lng = 16'd0;     act_low = 1'b0; end
                1: begin deb = 16'hFFFF;  gap = 16'hFFFF;  lng = 16'hFFFF;  act_low = 1'b1; end
                2: begin deb = 16'd5;     gap = 16'd30;    lng = 16'd60;    act_low = 1'b0; end
                3: begin deb = 16'd20;    gap = 16'd150;   lng = 16'd300;   act_low = 1'b1; end
                4: begin deb = 16'd1;     gap = 16'd10;    lng = 16'd1;     act_low = 1'b0; end
                5: begin
                    deb     = 16'($urandom());
                    gap     = 16'($urandom());
                    lng     = 16'($urandom());
                    act_low = 1'($urandom_range(0, 1));
                end
                default: begin
                    deb     = 16'($urandom_range(0, 40));
                    gap     = 16'($urandom_range(0, 300));
                    lng     = 16'($urandom_range(0, 600));
                    act_low = 1'($urandom_range(0, 1));
                end
            endcase
            write_reg(bcd_pkg::CFG_DEBOUNCE_TIME, deb);
            write_reg(bcd_pkg::CFG_CLICK_GAP, gap);
            write_reg(bcd_pkg::CFG_LONG_PRESS_TIME, lng);
            write_reg(bcd_pkg::CFG_ACTIVE_LOW, {15'd0, act_low});
            run_random(ITEMS_PER_RUN, 32'(deb), 32'(gap), 32'(lng), act_low);
        end
        drain();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_events.size() == 0) begin
            $display("button_click_detector_core test passed");
        end else begin
            $display("button_click_detector_core test failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/bcd_pkg.sv
rtl/bcd_debounce.sv
rtl/bcd_click_fsm.sv
rtl/button_click_detector_core.sv
rtl/bcd_checker.sv
sim/testbench.sv
